### rtl/csc_pkg.sv
package csc_pkg;

   // fixed widths of the item fields and registers
   localparam int SAMPLE_BITS    = 13;
   localparam int LIMIT_BITS     = 14;
   localparam int DIST_BITS      = 6;
   localparam int CSR_DATA_BITS  = 14;
   localparam int CSR_INDEX_BITS = 3;

   localparam int COLOR_BITS_DEFAULT = 14;
   localparam int COUNT_BITS_DEFAULT = 6;

   localparam int COLOR_START = 10000;

   localparam logic [LIMIT_BITS-1:0] WHITE_LIMIT_RESET    = 14'd2500;
   localparam logic [LIMIT_BITS-1:0] RED_LIMIT_RESET      = 14'd4600;
   localparam logic [DIST_BITS-1:0]  WHITE_DISTANCE_RESET = 6'd3;
   localparam logic [DIST_BITS-1:0]  RED_DISTANCE_RESET   = 6'd9;
   localparam logic [DIST_BITS-1:0]  BLUE_DISTANCE_RESET  = 6'd14;

   // ejector / bin choice codes
   localparam logic [1:0] CHOICE_WHITE = 2'd0;
   localparam logic [1:0] CHOICE_RED   = 2'd1;
   localparam logic [1:0] CHOICE_BLUE  = 2'd2;

   // bin report codes
   localparam logic [1:0] REPORT_NONE  = 2'd0;
   localparam logic [1:0] REPORT_WHITE = 2'd1;
   localparam logic [1:0] REPORT_RED   = 2'd2;
   localparam logic [1:0] REPORT_BLUE  = 2'd3;

   typedef enum logic [2:0] {
      MODE_WAIT  = 3'd0,
      MODE_SENSE = 3'd1,
      MODE_MOVE  = 3'd2,
      MODE_EJECT = 3'd3,
      MODE_BIN   = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WHITE_LIMIT    = 3'd0,
      CSR_RED_LIMIT      = 3'd1,
      CSR_WHITE_DISTANCE = 3'd2,
      CSR_RED_DISTANCE   = 3'd3,
      CSR_BLUE_DISTANCE  = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] white_limit;
      logic [LIMIT_BITS-1:0] red_limit;
      logic [DIST_BITS-1:0]  white_distance;
      logic [DIST_BITS-1:0]  red_distance;
      logic [DIST_BITS-1:0]  blue_distance;
   } cfg_type;

   typedef struct packed {
      logic                   entry_barrier_raw;
      logic                   exit_barrier_raw;
      logic                   pulse_key;
      logic [SAMPLE_BITS-1:0] color_sample;
      logic                   bin_white_raw;
      logic                   bin_red_raw;
      logic                   bin_blue_raw;
   } req_type;

   typedef struct packed {
      logic       conveyor_on;
      logic       compressor_on;
      logic       eject_fire;
      logic [1:0] eject_select;
      logic       bin_report_valid;
      logic [1:0] bin_report;
      logic [2:0] mode_code;
   } rsp_type;

endpackage

### rtl/csc_regs.sv
module csc_regs import csc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            CSR_WHITE_LIMIT:    cfg_in.white_limit    = csr_wdata[LIMIT_BITS-1:0];
            CSR_RED_LIMIT:      cfg_in.red_limit      = csr_wdata[LIMIT_BITS-1:0];
            CSR_WHITE_DISTANCE: cfg_in.white_distance = csr_wdata[DIST_BITS-1:0];
            CSR_RED_DISTANCE:   cfg_in.red_distance   = csr_wdata[DIST_BITS-1:0];
            CSR_BLUE_DISTANCE:  cfg_in.blue_distance  = csr_wdata[DIST_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.white_limit    <= WHITE_LIMIT_RESET;
         cfg_ff.red_limit      <= RED_LIMIT_RESET;
         cfg_ff.white_distance <= WHITE_DISTANCE_RESET;
         cfg_ff.red_distance   <= RED_DISTANCE_RESET;
         cfg_ff.blue_distance  <= BLUE_DISTANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/csc_seq.sv
module csc_seq import csc_pkg::*; #(
   parameter int COLOR_BITS = COLOR_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int CMP_BITS  = (COLOR_BITS > LIMIT_BITS) ? COLOR_BITS : LIMIT_BITS;
   localparam int DCMP_BITS = (COUNT_BITS > DIST_BITS) ? COUNT_BITS : DIST_BITS;
   localparam int COLOR_MAX = (1 << COLOR_BITS) - 1;
   localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
   localparam int START_VAL = (COLOR_START < COLOR_MAX) ? COLOR_START : COLOR_MAX;

   localparam logic [CMP_BITS-1:0]   COLOR_MAX_W = CMP_BITS'(COLOR_MAX);
   localparam logic [COLOR_BITS-1:0] COLOR_INIT  = COLOR_BITS'(START_VAL);
   localparam logic [DCMP_BITS-1:0]  COUNT_MAX_W = DCMP_BITS'(COUNT_MAX);

   mode_type                mode_ff, mode_in;
   logic [COLOR_BITS-1:0]   color_min_ff, color_min_in;
   logic [COUNT_BITS-1:0]   target_ff, target_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [1:0]              choice_ff, choice_in;
   logic                    last_pulse_ff, last_pulse_in;
   logic                    conveyor_ff, conveyor_in;
   logic                    compressor_ff, compressor_in;

   logic [CMP_BITS-1:0]     sample_w;
   logic [COLOR_BITS-1:0]   sample_c;
   logic [COLOR_BITS-1:0]   min_next;
   logic [CMP_BITS-1:0]     min_w;
   logic                    is_white;
   logic                    is_red;
   logic                    pulse_rise;
   logic [COUNT_BITS-1:0]   count_step;

   function automatic logic [COUNT_BITS-1:0] clamp_count(input logic [DIST_BITS-1:0] d);
      logic [DCMP_BITS-1:0] d_w;
      d_w = DCMP_BITS'(d);
      return (d_w < COUNT_MAX_W) ? COUNT_BITS'(d_w) : COUNT_BITS'(COUNT_MAX_W);
   endfunction

   // clamp the sample to the colour range, then track the minimum
   assign sample_w   = CMP_BITS'(req.color_sample);
   assign sample_c   = (sample_w > COLOR_MAX_W) ? COLOR_BITS'(COLOR_MAX_W)
                                                : COLOR_BITS'(sample_w);
   assign min_next   = (sample_c < color_min_ff) ? sample_c : color_min_ff;
   assign min_w      = CMP_BITS'(min_next);
   assign is_white   = min_w < CMP_BITS'(cfg.white_limit);
   assign is_red     = min_w < CMP_BITS'(cfg.red_limit);

   // counter saturates at all ones
   assign pulse_rise = req.pulse_key && !last_pulse_ff && (count_ff != '1);
   assign count_step = pulse_rise ? count_ff + COUNT_BITS'(1) : count_ff;

   always_comb begin
      mode_in       = mode_ff;
      color_min_in  = color_min_ff;
      target_in     = target_ff;
      count_in      = count_ff;
      choice_in     = choice_ff;
      last_pulse_in = last_pulse_ff;
      conveyor_in   = conveyor_ff;
      compressor_in = compressor_ff;
      result.eject_fire       = 1'b0;
      result.eject_select     = CHOICE_WHITE;
      result.bin_report_valid = 1'b0;
      result.bin_report       = REPORT_NONE;

      unique case (mode_ff)
         MODE_WAIT: begin
            if (!req.entry_barrier_raw) begin
               mode_in      = MODE_SENSE;
               conveyor_in  = 1'b1;
               color_min_in = COLOR_INIT;
            end
         end
         MODE_SENSE: begin
            color_min_in = min_next;
            if (!req.exit_barrier_raw) begin
               mode_in       = MODE_MOVE;
               count_in      = '0;
               compressor_in = 1'b1;
               if (is_white) begin
                  target_in = clamp_count(cfg.white_distance);
                  choice_in = CHOICE_WHITE;
               end else if (is_red) begin
                  target_in = clamp_count(cfg.red_distance);
                  choice_in = CHOICE_RED;
               end else begin
                  target_in = clamp_count(cfg.blue_distance);
                  choice_in = CHOICE_BLUE;
               end
            end
         end
         MODE_MOVE: begin
            count_in      = count_step;
            last_pulse_in = req.pulse_key;
            if (count_step >= target_ff) begin
               mode_in     = MODE_EJECT;
               conveyor_in = 1'b0;
            end
         end
         MODE_EJECT: begin
            result.eject_fire   = 1'b1;
            result.eject_select = choice_ff;
            mode_in             = MODE_BIN;
         end
         MODE_BIN: begin
            result.bin_report_valid = 1'b1;
            if (!req.bin_white_raw) begin
               result.bin_report = REPORT_WHITE;
            end else if (!req.bin_red_raw) begin
               result.bin_report = REPORT_RED;
            end else if (!req.bin_blue_raw) begin
               result.bin_report = REPORT_BLUE;
            end
            mode_in = MODE_WAIT;
         end
         default: begin
            mode_in = MODE_WAIT;
         end
      endcase

      result.conveyor_on   = conveyor_in;
      result.compressor_on = compressor_in;
      result.mode_code     = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_WAIT;
         color_min_ff  <= COLOR_INIT;
         target_ff     <= '0;
         count_ff      <= '0;
         choice_ff     <= CHOICE_BLUE;
         last_pulse_ff <= 1'b0;
         conveyor_ff   <= 1'b0;
         compressor_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         color_min_ff  <= color_min_in;
         target_ff     <= target_in;
         count_ff      <= count_in;
         choice_ff     <= choice_in;
         last_pulse_ff <= last_pulse_in;
         conveyor_ff   <= conveyor_in;
         compressor_ff <= compressor_in;
      end
   end

endmodule

### rtl/csc_out.sv
module csc_out import csc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_in,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // a new item may enter when the register is empty or being drained
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### rtl/color_sort_conveyor_sequencer.sv
// Colour sort conveyor sequencer.
// Each req item is one scan tick of the sensor levels (barriers, pulse key,
// colour sample, bin barriers); every item yields exactly one rsp item with
// the drive levels, eject command, bin report and the mode after the tick.
// The sequence runs wait, colour sensing, counted move, eject and bin check.
// Channels use valid/ready; csr_wr_en with csr_index and csr_wdata writes
// the limits and distances; the user must write only while no item is in
// flight; the block does not enforce it. An item's result is on rsp in the
// cycle after it is accepted; one item per cycle is taken while the output
// register is free. The mode and counter update is a single combinational
// pass between the state registers, bounded by the colour minimum and limit
// compares. The result sits in one output register; req_ready is high while
// that register is empty or being taken, so a stalled receiver holds the
// item there and back-pressures req in the same cycle.
// Reset (synchronous, active high) returns to waiting, clears the output
// register and loads the default limits and distances.
module color_sort_conveyor_sequencer import csc_pkg::*; #(
   parameter int COLOR_BITS = COLOR_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg;
   rsp_type step_rsp;
   logic    step_en;
   logic    out_free;

   assign req_ready = out_free;
   assign step_en   = req_valid && out_free;

   csc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csc_seq #(
      .COLOR_BITS (COLOR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_data),
      .cfg     (cfg),
      .result  (step_rsp)
   );

   csc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step_en),
      .rsp_in    (step_rsp),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/csc_checker.sv
module csc_checker import csc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed");

   // an eject tick is always followed by the bin check with the belt stopped
   a_eject_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.eject_fire |->
         rsp_data.mode_code == MODE_BIN && !rsp_data.conveyor_on
         && rsp_data.compressor_on)
      else $error("eject item with wrong mode or drive levels");

   // the bin report closes the cycle
   a_bin_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bin_report_valid |->
         rsp_data.mode_code == MODE_WAIT && !rsp_data.eject_fire)
      else $error("bin report item not back in waiting");

   // with a full, stalled output register no new item may enter
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while rsp stalled");

endmodule

bind color_sort_conveyor_sequencer csc_checker u_csc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
